### src/hfd_pkg.sv
`default_nettype none
package hfd_pkg;

   // Node word layout: leaf flag, symbol, left child, right child.
   localparam int NODE_W    = 27;
   localparam int IDX_W     = 9;
   localparam int SYM_W     = 8;
   localparam int CNT_W     = 21;
   localparam int NBITS_W   = 4;
   localparam int LEAF_BIT  = 26;
   localparam int SYM_LSB   = 18;
   localparam int LEFT_LSB  = 9;
   localparam int RIGHT_LSB = 0;

   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_DECODE = 2'd1;
   localparam logic [1:0] MODE_START  = 2'd2;

   localparam logic CSR_EXPECTED = 1'b0;
   localparam logic CSR_ROOT     = 1'b1;

   typedef struct packed {
      logic             push;
      logic             flush;
      logic [SYM_W-1:0] sym;
      logic             done;
   } hfd_emit_type;

endpackage
`default_nettype wire

### src/huffman_tree_bit_decoder_core.sv
`default_nettype none
// Bit-serial Huffman decoder. Load requests (mode 0) write one tree node into the
// node store, start requests (mode 2) put the walk at root_node and clear the symbol
// count, and decode requests (mode 1) feed up to eight code bits, MSB first, that walk
// the tree one node per bit; each leaf reached yields one response, the final one of
// a code byte flagged last and the one that meets expected_symbols flagged done_res.
// Load and start requests are handled in the idle state. A decode request reads the
// walk node for each bit and then the chosen child, with no child read when the walk
// already stands on a leaf, and stays idle when it has no bit to decode or the count is met.
// The node store's single read port gives one node per cycle unless the walk stalls: a
// child is read and then tested before the next bit. Requests are taken one at a time;
// a response waits in an output register and a one-deep hold stage, so a slow consumer
// stalls the walk only when both are full. Never read a node that was not loaded.
module huffman_tree_bit_decoder_core #(
   parameter int TREE_NODES = 512
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [1:0]                 req_mode,
   input  wire logic [hfd_pkg::IDX_W-1:0]  req_node_index,
   input  wire logic                       req_node_is_leaf,
   input  wire logic [hfd_pkg::SYM_W-1:0]  req_node_symbol,
   input  wire logic [hfd_pkg::IDX_W-1:0]  req_left_child,
   input  wire logic [hfd_pkg::IDX_W-1:0]  req_right_child,
   input  wire logic [7:0]                 req_code_byte,
   input  wire logic [hfd_pkg::NBITS_W-1:0] req_valid_bits,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [hfd_pkg::SYM_W-1:0]       rsp_symbol,
   output logic                            rsp_last,
   output logic                            rsp_done_res,
   input  wire logic                       csr_write_en,
   input  wire logic                       csr_index,
   input  wire logic [hfd_pkg::CNT_W-1:0]  csr_wdata
);
   import hfd_pkg::*;

   localparam int AW = $clog2(TREE_NODES);
   localparam logic [IDX_W:0] IDX_LIMIT = (IDX_W + 1)'(TREE_NODES);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CUR   = 2'd1;  // node store output holds the walk node
   localparam logic [1:0] ST_CHILD = 2'd2;  // node store output holds the chosen child
   localparam logic [1:0] ST_FLUSH = 2'd3;  // release the held symbol flagged last

   logic [1:0]         state_ff, state_in;
   logic [IDX_W-1:0]   walk_ff, walk_in;
   logic [IDX_W-1:0]   child_ff, child_in;
   logic [7:0]         byte_ff, byte_in;
   logic [NBITS_W-1:0] left_ff, left_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   expected_ff;
   logic [IDX_W-1:0]   root_ff;
   logic               rd_oob_ff, rd_oob_in;

   logic               rd_en;
   logic [IDX_W-1:0]   rd_idx;
   logic [NODE_W-1:0]  rd_data;
   logic [NODE_W-1:0]  word;
   logic               wr_en;
   logic [NODE_W-1:0]  wr_data;
   logic               accept;
   logic               slot_free;
   hfd_emit_type       emit;

   logic               step;
   logic               emitted;
   logic [CNT_W-1:0]   cnt_new;
   logic [NBITS_W-1:0] nbits;
   logic               node_leaf;
   logic [SYM_W-1:0]   node_sym;
   logic [IDX_W-1:0]   node_left;
   logic [IDX_W-1:0]   node_right;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // An index past the store reads as an all-zero interior node.
   assign word       = rd_oob_ff ? '0 : rd_data;
   assign node_leaf  = word[LEAF_BIT];
   assign node_sym   = word[SYM_LSB +: SYM_W];
   assign node_left  = word[LEFT_LSB +: IDX_W];
   assign node_right = word[RIGHT_LSB +: IDX_W];

   assign wr_en   = accept && (req_mode == MODE_LOAD) && ({1'b0, req_node_index} < IDX_LIMIT);
   assign wr_data = {req_node_is_leaf, req_node_symbol, req_left_child, req_right_child};

   assign nbits   = (req_valid_bits > NBITS_W'(8)) ? NBITS_W'(8) : req_valid_bits;
   assign cnt_new = count_ff + CNT_W'(emitted);

   always_comb begin
      state_in  = state_ff;
      walk_in   = walk_ff;
      child_in  = child_ff;
      byte_in   = byte_ff;
      left_in   = left_ff;
      count_in  = count_ff;
      rd_en     = 1'b0;
      rd_idx    = walk_ff;
      step      = 1'b0;
      emitted   = 1'b0;
      emit.push  = 1'b0;
      emit.flush = 1'b0;
      emit.sym   = node_sym;
      emit.done  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_START: begin
                     walk_in  = root_ff;
                     count_in = '0;
                  end
                  MODE_DECODE: begin
                     byte_in = req_code_byte;
                     left_in = nbits;
                     // Fetch the walk node unless nothing is left to decode.
                     if (nbits != '0 && count_ff < expected_ff) begin
                        rd_en    = 1'b1;
                        rd_idx   = walk_ff;
                        state_in = ST_CUR;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CUR: begin
            if (node_leaf) begin
               // Walk stands on a leaf: this bit emits it.
               if (slot_free) begin
                  emitted = 1'b1;
                  step    = 1'b1;
               end
            end else begin
               child_in = byte_ff[7] ? node_right : node_left;
               rd_en    = 1'b1;
               rd_idx   = child_in;
               state_in = ST_CHILD;
            end
         end
         ST_CHILD: begin
            if (node_leaf) begin
               if (slot_free) begin
                  emitted = 1'b1;
                  step    = 1'b1;
               end
            end else begin
               // Child is interior: its word already sits on the read port.
               walk_in = child_ff;
               step    = 1'b1;
            end
         end
         default: begin
            emit.flush = 1'b1;
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase

      if (emitted) begin
         emit.push = 1'b1;
         emit.done = (cnt_new == expected_ff);
         walk_in   = root_ff;
         rd_en     = 1'b1;
         rd_idx    = root_ff;
      end

      if (step) begin
         // Advance to the next code bit or stop at the byte end or the count.
         count_in = cnt_new;
         byte_in  = {byte_ff[6:0], 1'b0};
         left_in  = left_ff - NBITS_W'(1);
         if (left_ff == NBITS_W'(1) || cnt_new >= expected_ff) begin
            state_in = ST_FLUSH;
         end else begin
            state_in = ST_CUR;
         end
      end

      rd_oob_in = rd_en ? ({1'b0, rd_idx} >= IDX_LIMIT) : rd_oob_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         walk_ff     <= '0;
         count_ff    <= '0;
         expected_ff <= '0;
         root_ff     <= '0;
      end else begin
         state_ff <= state_in;
         walk_ff  <= walk_in;
         count_ff <= count_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_EXPECTED: expected_ff <= csr_wdata;
               CSR_ROOT:     root_ff     <= csr_wdata[IDX_W-1:0];
               default: begin
               end
            endcase
         end
      end
      child_ff  <= child_in;
      byte_ff   <= byte_in;
      left_ff   <= left_in;
      rd_oob_ff <= rd_oob_in;
   end

   hfd_ram #(
      .WIDTH(NODE_W),
      .DEPTH(TREE_NODES)
   ) u_node_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(req_node_index[AW-1:0]),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_idx[AW-1:0]),
      .rd_data(rd_data)
   );

   hfd_rsp_stage u_rsp (
      .clock       (clock),
      .reset       (reset),
      .emit        (emit),
      .slot_free   (slot_free),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_symbol  (rsp_symbol),
      .rsp_last    (rsp_last),
      .rsp_done_res(rsp_done_res)
   );

endmodule
`default_nettype wire

### src/hfd_ram.sv
`default_nettype none
module hfd_ram #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

### src/hfd_rsp_stage.sv
`default_nettype none
module hfd_rsp_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire hfd_pkg::hfd_emit_type emit,
   output logic                      slot_free,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [hfd_pkg::SYM_W-1:0] rsp_symbol,
   output logic                      rsp_last,
   output logic                      rsp_done_res
);
   import hfd_pkg::*;

   // Hold the newest symbol back until we know whether it closes the byte.
   logic             pend_v_ff, pend_v_in;
   logic [SYM_W-1:0] pend_sym_ff, pend_sym_in;
   logic             pend_done_ff, pend_done_in;
   logic             out_v_ff, out_v_in;
   logic [SYM_W-1:0] out_sym_ff, out_sym_in;
   logic             out_last_ff, out_last_in;
   logic             out_done_ff, out_done_in;
   logic             out_free;

   assign out_free  = !out_v_ff || rsp_ready;
   assign slot_free = !pend_v_ff || out_free;

   always_comb begin
      pend_v_in    = pend_v_ff;
      pend_sym_in  = pend_sym_ff;
      pend_done_in = pend_done_ff;
      out_v_in     = out_v_ff && !rsp_ready;
      out_sym_in   = out_sym_ff;
      out_last_in  = out_last_ff;
      out_done_in  = out_done_ff;
      if ((emit.push || emit.flush) && slot_free) begin
         if (pend_v_ff) begin
            out_v_in    = 1'b1;
            out_sym_in  = pend_sym_ff;
            out_done_in = pend_done_ff;
            out_last_in = emit.flush;
         end
         if (emit.push) begin
            pend_v_in    = 1'b1;
            pend_sym_in  = emit.sym;
            pend_done_in = emit.done;
         end else begin
            pend_v_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
      pend_sym_ff  <= pend_sym_in;
      pend_done_ff <= pend_done_in;
      out_sym_ff   <= out_sym_in;
      out_last_ff  <= out_last_in;
      out_done_ff  <= out_done_in;
   end

   assign rsp_valid    = out_v_ff;
   assign rsp_symbol   = out_sym_ff;
   assign rsp_last     = out_last_ff;
   assign rsp_done_res = out_done_ff;

endmodule
`default_nettype wire
